/* src/abb_pkg.sv */
`default_nettype none

package abb_pkg;

    // Rotation stages of each CORDIC rotator (8 to 24)
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;

    // Field widths
    localparam int COORD_W = 32;
    localparam int RAD_W   = 31;
    localparam int ANG_W   = 16;
    localparam int FRAC_W  = ANG_W - 2;

    // CORDIC datapath widths, Q2.30 with headroom
    localparam int XW     = 34;
    localparam int ZW     = 33;
    localparam int TRIG_W = 32;
    localparam int PROD_W = 2 * TRIG_W;
    localparam int SUM_W  = COORD_W + 2;
    localparam int GAIN_Q30 = 652032874;
    localparam int ROUND_SHIFT = 30;

    // Pipeline shape: input stage, rotations, quadrant fix-up,
    // three placement stages, box select
    localparam int LATENCY    = CORDIC_STAGES + 6;
    localparam int SIDE_DEPTH = CORDIC_STAGES + 4;
    localparam int ST_TRIG    = CORDIC_STAGES + 1;
    localparam int ST_OFFSET  = CORDIC_STAGES + 3;

    // Quadrant codes (top two angle bits)
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Axis extremes as binary angles
    localparam logic [ANG_W-1:0] ANG_0   = 16'd0;
    localparam logic [ANG_W-1:0] ANG_90  = 16'd16384;
    localparam logic [ANG_W-1:0] ANG_180 = 16'd32768;
    localparam logic [ANG_W-1:0] ANG_270 = 16'd49152;

    // Sweep flag positions
    localparam int SW_XMIN = 0;
    localparam int SW_XMAX = 1;
    localparam int SW_YMIN = 2;
    localparam int SW_YMAX = 3;

    // atan(2^-i) in units of a 32-bit turn
    localparam logic [31:0] ATAN_TURN32 [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [RAD_W-1:0]          rad;
        logic [3:0]                sweep;
    } t_side;

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [COORD_W-1:0] res;
        if (v > SUM_W'(64'sd2147483647)) begin
            res = COORD_W'(64'sd2147483647);
        end else if (v < -SUM_W'(64'sd2147483648)) begin
            res = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

    // Inclusive sweep test of angle a over the arc lo..hi
    function automatic logic sweeps(input logic [ANG_W-1:0] a, input logic [ANG_W-1:0] lo,
                                    input logic [ANG_W-1:0] hi, input logic ccw);
        logic res;
        if (ccw) begin
            res = (lo < hi) ? (a >= lo && a <= hi) : (a >= lo || a <= hi);
        end else begin
            res = (lo < hi) ? !(a > lo && a < hi) : !(a > lo || a < hi);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* src/abb_cordic.sv */
`default_nettype none

module abb_cordic (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [abb_pkg::ANG_W-1:0]          i_angle,
    output logic signed [abb_pkg::TRIG_W-1:0]  o_cos,
    output logic signed [abb_pkg::TRIG_W-1:0]  o_sin
);
    import abb_pkg::*;

    logic signed [XW-1:0] r_x [CORDIC_STAGES];
    logic signed [XW-1:0] r_y [CORDIC_STAGES];
    logic signed [ZW-1:0] r_z [CORDIC_STAGES];
    logic [1:0]           r_q [CORDIC_STAGES];
    logic signed [XW-1:0] n_cos;
    logic signed [XW-1:0] n_sin;
    logic signed [XW-1:0] w_xl;
    logic signed [XW-1:0] w_yl;

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        logic signed [XW-1:0] w_xi;
        logic signed [XW-1:0] w_yi;
        logic signed [ZW-1:0] w_zi;
        logic [1:0]           w_qi;
        logic signed [XW-1:0] w_dx;
        logic signed [XW-1:0] w_dy;
        logic signed [ZW-1:0] w_at;

        if (i == 0) begin : g_first
            assign w_xi = XW'(GAIN_Q30);
            assign w_yi = '0;
            assign w_zi = {{(ZW-FRAC_W-16){1'b0}}, i_angle[FRAC_W-1:0], 16'b0};
            assign w_qi = i_angle[ANG_W-1:FRAC_W];
        end else begin : g_next
            assign w_xi = r_x[i-1];
            assign w_yi = r_y[i-1];
            assign w_zi = r_z[i-1];
            assign w_qi = r_q[i-1];
        end

        assign w_dx = w_yi >>> i;
        assign w_dy = w_xi >>> i;
        assign w_at = ZW'(ATAN_TURN32[i]);

        // rotate towards zero residual angle
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!w_zi[ZW-1]) begin
                    r_x[i] <= w_xi - w_dx;
                    r_y[i] <= w_yi + w_dy;
                    r_z[i] <= w_zi - w_at;
                end else begin
                    r_x[i] <= w_xi + w_dx;
                    r_y[i] <= w_yi - w_dy;
                    r_z[i] <= w_zi + w_at;
                end
                r_q[i] <= w_qi;
            end
        end
    end

    assign w_xl = r_x[CORDIC_STAGES-1];
    assign w_yl = r_y[CORDIC_STAGES-1];

    // quadrant fold-back by swap and negate
    always_comb begin
        case (r_q[CORDIC_STAGES-1])
            QUAD_0: begin
                n_cos = w_xl;
                n_sin = w_yl;
            end
            QUAD_1: begin
                n_cos = -w_yl;
                n_sin = w_xl;
            end
            QUAD_2: begin
                n_cos = -w_xl;
                n_sin = -w_yl;
            end
            default: begin
                n_cos = w_yl;
                n_sin = -w_xl;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= n_cos[TRIG_W-1:0];
            o_sin <= n_sin[TRIG_W-1:0];
        end
    end

endmodule

`default_nettype wire

/* src/abb_place.sv */
`default_nettype none

module abb_place (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [abb_pkg::RAD_W-1:0]           i_radius,
    input  logic signed [abb_pkg::TRIG_W-1:0]   i_trig,
    input  logic signed [abb_pkg::COORD_W-1:0]  i_center,
    output logic signed [abb_pkg::COORD_W-1:0]  o_coord
);
    import abb_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  r_off;
    logic signed [PROD_W-1:0] w_round;
    logic signed [TRIG_W-1:0] w_rad;
    logic signed [SUM_W-1:0]  w_sum;

    assign w_rad   = signed'({1'b0, i_radius});
    assign w_round = r_prod + PROD_W'(64'sd536870912);
    assign w_sum   = SUM_W'(i_center) + r_off;

    // product, round-half-up offset, then saturated sum with the centre
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= PROD_W'(w_rad) * PROD_W'(i_trig);
            r_off   <= w_round[ROUND_SHIFT +: SUM_W];
            o_coord <= sat32(w_sum);
        end
    end

endmodule

`default_nettype wire

/* src/arc_bounding_box.sv */
`default_nettype none

// Axis-aligned bounding box of a circular arc. Each input word carries one
// arc: centre and radius in Q16.16, start and end angle as 16-bit binary
// angles (65536 is a full turn) and the sweep direction in tuser. The block
// turns both angles into cosine and sine with two unrolled CORDIC rotators,
// places the endpoints at centre plus radius times cosine and sine (rounded,
// saturated), and for each of the four axis extremes either takes
// centre plus or minus radius, when the sweep passes that extreme, or the
// lesser or greater endpoint coordinate. Equal angles give a full circle when
// counter-clockwise and a single point when clockwise. One arc is accepted
// every cycle while the output is not stalled; each result word passes through
// an input register, the CORDIC_STAGES rotation stages (16 stages here), a
// quadrant fix-up register, the placement registers and the box select
// register. The whole pipeline advances whenever the output register is
// empty or being taken, so a stall at the output holds every stage and loses nothing.
module arc_bounding_box (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // center_x[31:0], center_y[63:32], arc_radius[94:64],
    // start_angle[110:95], end_angle[126:111], zero[127]
    input  logic [127:0] i_s_axis_tdata,
    // counter_clockwise[0]
    input  logic [0:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // box_x_min[31:0], box_x_max[63:32], box_y_min[95:64], box_y_max[127:96]
    output logic [127:0] o_m_axis_tdata
);
    import abb_pkg::*;

    logic [LATENCY-1:0]          r_vld;
    logic                        w_en;
    logic                        w_acc;
    t_side                       r_side [SIDE_DEPTH];
    t_side                       n_side;
    logic [ANG_W-1:0]            r_start;
    logic [ANG_W-1:0]            r_end;
    logic signed [TRIG_W-1:0]    w_ca;
    logic signed [TRIG_W-1:0]    w_sa;
    logic signed [TRIG_W-1:0]    w_cb;
    logic signed [TRIG_W-1:0]    w_sb;
    logic signed [COORD_W-1:0]   w_ax;
    logic signed [COORD_W-1:0]   w_ay;
    logic signed [COORD_W-1:0]   w_bx;
    logic signed [COORD_W-1:0]   w_by;
    logic signed [COORD_W-1:0]   r_xm;
    logic signed [COORD_W-1:0]   r_xp;
    logic signed [COORD_W-1:0]   r_ym;
    logic signed [COORD_W-1:0]   r_yp;
    logic [3:0]                  r_sweep;
    logic signed [COORD_W-1:0]   n_xmin;
    logic signed [COORD_W-1:0]   n_xmax;
    logic signed [COORD_W-1:0]   n_ymin;
    logic signed [COORD_W-1:0]   n_ymax;
    logic signed [SUM_W-1:0]     w_xm;
    logic signed [SUM_W-1:0]     w_xp;
    logic signed [SUM_W-1:0]     w_ym;
    logic signed [SUM_W-1:0]     w_yp;
    logic [127:0]                r_box;
    t_side                       w_late;

    // advance everything when the output word is free or being taken
    assign w_en            = !r_vld[LATENCY-1] || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign w_acc           = i_s_axis_tvalid && w_en;
    assign o_m_axis_tvalid = r_vld[LATENCY-1];
    assign o_m_axis_tdata  = r_box;

    // unpack the input word; sweep flags are worked out on entry
    always_comb begin
        n_side.cx  = i_s_axis_tdata[31:0];
        n_side.cy  = i_s_axis_tdata[63:32];
        n_side.rad = i_s_axis_tdata[94:64];
        n_side.sweep[SW_XMIN] = sweeps(ANG_270, i_s_axis_tdata[110:95],
                                       i_s_axis_tdata[126:111], i_s_axis_tuser[0]);
        n_side.sweep[SW_XMAX] = sweeps(ANG_90, i_s_axis_tdata[110:95],
                                       i_s_axis_tdata[126:111], i_s_axis_tuser[0]);
        n_side.sweep[SW_YMIN] = sweeps(ANG_180, i_s_axis_tdata[110:95],
                                       i_s_axis_tdata[126:111], i_s_axis_tuser[0]);
        n_side.sweep[SW_YMAX] = sweeps(ANG_0, i_s_axis_tdata[110:95],
                                       i_s_axis_tdata[126:111], i_s_axis_tuser[0]);
    end

    // valid bits travel with the words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LATENCY-2:0], i_s_axis_tvalid};
        end
    end

    // centre, radius and sweep flags ride alongside the rotators
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= n_side;
            r_start   <= i_s_axis_tdata[110:95];
            r_end     <= i_s_axis_tdata[126:111];
            for (int k = 1; k < SIDE_DEPTH; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    abb_cordic u_cordic_a (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (r_start),
        .o_cos   (w_ca),
        .o_sin   (w_sa)
    );

    abb_cordic u_cordic_b (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (r_end),
        .o_cos   (w_cb),
        .o_sin   (w_sb)
    );

    abb_place u_place_ax (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_radius (r_side[ST_TRIG].rad),
        .i_trig   (w_ca),
        .i_center (r_side[ST_OFFSET].cx),
        .o_coord  (w_ax)
    );

    abb_place u_place_ay (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_radius (r_side[ST_TRIG].rad),
        .i_trig   (w_sa),
        .i_center (r_side[ST_OFFSET].cy),
        .o_coord  (w_ay)
    );

    abb_place u_place_bx (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_radius (r_side[ST_TRIG].rad),
        .i_trig   (w_cb),
        .i_center (r_side[ST_OFFSET].cx),
        .o_coord  (w_bx)
    );

    abb_place u_place_by (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_radius (r_side[ST_TRIG].rad),
        .i_trig   (w_sb),
        .i_center (r_side[ST_OFFSET].cy),
        .o_coord  (w_by)
    );

    // full-circle extremes, in step with the endpoint sums
    assign w_late = r_side[ST_OFFSET];
    assign w_xm   = SUM_W'(w_late.cx) - SUM_W'({1'b0, w_late.rad});
    assign w_xp   = SUM_W'(w_late.cx) + SUM_W'({1'b0, w_late.rad});
    assign w_ym   = SUM_W'(w_late.cy) - SUM_W'({1'b0, w_late.rad});
    assign w_yp   = SUM_W'(w_late.cy) + SUM_W'({1'b0, w_late.rad});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xm    <= sat32(w_xm);
            r_xp    <= sat32(w_xp);
            r_ym    <= sat32(w_ym);
            r_yp    <= sat32(w_yp);
            r_sweep <= w_late.sweep;
        end
    end

    // pick the extreme or the lesser or greater endpoint for each box edge
    always_comb begin
        n_xmin = r_sweep[SW_XMIN] ? r_xm : ((w_bx < w_ax) ? w_bx : w_ax);
        n_xmax = r_sweep[SW_XMAX] ? r_xp : ((w_bx > w_ax) ? w_bx : w_ax);
        n_ymin = r_sweep[SW_YMIN] ? r_ym : ((w_by < w_ay) ? w_by : w_ay);
        n_ymax = r_sweep[SW_YMAX] ? r_yp : ((w_by > w_ay) ? w_by : w_ay);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_box <= {n_ymax, n_ymin, n_xmax, n_xmin};
        end
    end

`ifndef ASSERT_OFF
    a_ready_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with an empty output register");

    a_accept_enters : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_vld[0])
        else $error("accepted word missing from the first stage");

    a_stall_freezes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

    a_drain : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && !r_vld[LATENCY-2]) |=> !o_m_axis_tvalid)
        else $error("result word repeated after it was taken");
`endif

endmodule

`default_nettype wire

/* bench/arc_bounding_box_test.sv */
`timescale 1ns / 100ps

module arc_bounding_box_test;

    import abb_pkg::*;

    localparam int HOLD_OFF_CYCLES = 120;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int RANDOM_PER_MIX  = 250;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [RAD_W-1:0]          rad;
        logic [ANG_W-1:0]          start_ang;
        logic [ANG_W-1:0]          end_ang;
        logic                      ccw;
    } arc_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_min;
        logic signed [COORD_W-1:0] x_max;
        logic signed [COORD_W-1:0] y_min;
        logic signed [COORD_W-1:0] y_max;
    } box_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    // center_x[31:0], center_y[63:32], arc_radius[94:64],
    // start_angle[110:95], end_angle[126:111], zero[127]
    logic [127:0] i_s_axis_tdata = '0;
    // counter_clockwise[0]
    logic [0:0]   i_s_axis_tuser = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    // box_x_min[31:0], box_x_max[63:32], box_y_min[95:64], box_y_max[127:96]
    logic [127:0] o_m_axis_tdata;

    arc_t arc_queue[$];     // arcs waiting to be offered, head is on the bus
    box_t box_expect[$];    // predicted boxes in arrival order

    int tx_idle_pct = 30;
    int rx_idle_pct = 74;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    int fail_count = 0;
    int arcs_sent = 0;
    int arcs_cw = 0;
    int arcs_equal = 0;
    int boxes_saturated = 0;
    int boxes_checked = 0;

    arc_bounding_box u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // Cosine and sine of a binary angle in Q2.30: rotate the low 14 bits
    // through the CORDIC stages, then fold in the quadrant exactly.
    function automatic void unit_vector(input logic [ANG_W-1:0] ang,
                                        output longint cos_q30, output longint sin_q30);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        int     i;
        x = GAIN_Q30;
        y = 0;
        z = longint'(ang[FRAC_W-1:0]) << 16;
        for (i = 0; i < CORDIC_STAGES && i < ATAN_ENTRIES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ATAN_TURN32[i]);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ATAN_TURN32[i]);
            end
        end
        case (ang[ANG_W-1:ANG_W-2])
            QUAD_0: begin
                cos_q30 = x;
                sin_q30 = y;
            end
            QUAD_1: begin
                cos_q30 = -y;
                sin_q30 = x;
            end
            QUAD_2: begin
                cos_q30 = -x;
                sin_q30 = -y;
            end
            default: begin
                cos_q30 = y;
                sin_q30 = -x;
            end
        endcase
    endfunction

    function automatic longint clamp_q16(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Endpoint coordinate: centre plus radius times trig, rounded half up
    function automatic longint endpoint(input longint centre, input longint rad,
                                        input longint trig_q30);
        return clamp_q16(centre + ((rad * trig_q30 + (longint'(1) << 29)) >>> 30));
    endfunction

    // Does the sweep from lo to hi pass angle ang (ends included)?
    // Clockwise passes whatever the open counter-clockwise interval misses.
    function automatic logic arc_covers(input logic [ANG_W-1:0] ang, input logic [ANG_W-1:0] lo,
                                        input logic [ANG_W-1:0] hi, input logic ccw);
        if (ccw) begin
            if (lo < hi) begin
                return ang >= lo && ang <= hi;
            end
            return ang >= lo || ang <= hi;
        end
        if (lo < hi) begin
            return ang <= lo || ang >= hi;
        end
        return ang <= lo && ang >= hi;
    endfunction

    function automatic box_t arc_box(input arc_t arc);
        longint cx;
        longint cy;
        longint rad;
        longint ca;
        longint sa;
        longint cb;
        longint sb;
        longint ax;
        longint ay;
        longint bx;
        longint by;
        box_t   box;
        cx  = $signed(arc.cx);
        cy  = $signed(arc.cy);
        rad = longint'(arc.rad);
        unit_vector(arc.start_ang, ca, sa);
        unit_vector(arc.end_ang, cb, sb);
        ax = endpoint(cx, rad, ca);
        ay = endpoint(cy, rad, sa);
        bx = endpoint(cx, rad, cb);
        by = endpoint(cy, rad, sb);
        box.x_min = arc_covers(ANG_270, arc.start_ang, arc.end_ang, arc.ccw) ?
                    COORD_W'(clamp_q16(cx - rad)) : COORD_W'((bx < ax) ? bx : ax);
        box.x_max = arc_covers(ANG_90, arc.start_ang, arc.end_ang, arc.ccw) ?
                    COORD_W'(clamp_q16(cx + rad)) : COORD_W'((bx > ax) ? bx : ax);
        box.y_min = arc_covers(ANG_180, arc.start_ang, arc.end_ang, arc.ccw) ?
                    COORD_W'(clamp_q16(cy - rad)) : COORD_W'((by < ay) ? by : ay);
        box.y_max = arc_covers(ANG_0, arc.start_ang, arc.end_ang, arc.ccw) ?
                    COORD_W'(clamp_q16(cy + rad)) : COORD_W'((by > ay) ? by : ay);
        return box;
    endfunction

    function automatic logic is_extreme(input logic [COORD_W-1:0] v);
        return v == 32'h7FFF_FFFF || v == 32'h8000_0000;
    endfunction

    task automatic queue_arc(input logic [31:0] cx, input logic [31:0] cy,
                             input logic [30:0] rad, input logic [15:0] a_start,
                             input logic [15:0] a_end, input logic ccw);
        arc_t arc;
        arc.cx        = cx;
        arc.cy        = cy;
        arc.rad       = rad;
        arc.start_ang = a_start;
        arc.end_ang   = a_end;
        arc.ccw       = ccw;
        arc_queue = {arc_queue, arc};
    endtask

    // Angle near an axis extreme, a few steps either side of it
    function automatic logic [ANG_W-1:0] near_axis();
        return {2'($urandom_range(0, 3)), 14'd0} + 16'($urandom_range(0, 6)) - 16'd3;
    endfunction

    function automatic arc_t random_arc();
        arc_t arc;
        case ($urandom_range(0, 3))
            0: arc.rad = RAD_W'($urandom());
            1: arc.rad = RAD_W'($urandom_range(0, 1 << 20));
            2: arc.rad = RAD_W'($urandom()) >> $urandom_range(0, 30);
            default: arc.rad = 31'h7FFF_FFFF - RAD_W'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 7))
            0: arc.cx = 32'h7FFF_FFFF - 32'($urandom_range(0, 1 << 16));
            1: arc.cx = 32'h8000_0000 + 32'($urandom_range(0, 1 << 16));
            default: arc.cx = $urandom();
        endcase
        case ($urandom_range(0, 7))
            0: arc.cy = 32'h7FFF_FFFF - 32'($urandom_range(0, 1 << 16));
            1: arc.cy = 32'h8000_0000 + 32'($urandom_range(0, 1 << 16));
            default: arc.cy = $urandom();
        endcase
        arc.start_ang = ($urandom_range(0, 3) == 0) ? near_axis() : ANG_W'($urandom());
        case ($urandom_range(0, 7))
            0: arc.end_ang = arc.start_ang;
            1: arc.end_ang = near_axis();
            default: arc.end_ang = ANG_W'($urandom());
        endcase
        arc.ccw = 1'($urandom());
        return arc;
    endfunction

    task automatic check_edge(input string name, input logic [COORD_W-1:0] want,
                              input logic [COORD_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            fail_count++;
        end
    endtask

    // Sender: offer the head of the arc queue, hold it until taken, then
    // predict its box on acceptance.
    always @(posedge i_clk) begin
        arc_t arc;
        box_t box;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                arc = arc_queue.pop_front();
                box = arc_box(arc);
                box_expect = {box_expect, box};
                arcs_sent++;
                if (!arc.ccw) begin
                    arcs_cw++;
                end
                if (arc.start_ang == arc.end_ang) begin
                    arcs_equal++;
                end
                if (is_extreme(box.x_min) || is_extreme(box.x_max) ||
                    is_extreme(box.y_min) || is_extreme(box.y_max)) begin
                    boxes_saturated++;
                end
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (arc_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    arc = arc_queue[0];
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {1'b0, arc.end_ang, arc.start_ang, arc.rad,
                                        arc.cy, arc.cx};
                    i_s_axis_tuser  <= arc.ccw;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            i_m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            i_m_axis_tready <= 1'b0;
            hold_served <= hold_served + 1;
            hold_left <= HOLD_OFF_CYCLES;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Result check: compare each word taken with the oldest predicted box
    always @(posedge i_clk) begin
        box_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (box_expect.size() == 0) begin
                $error("box word %h arrived with no arc outstanding", o_m_axis_tdata);
                fail_count++;
            end else begin
                want = box_expect.pop_front();
                check_edge("box_x_min", want.x_min, o_m_axis_tdata[31:0]);
                check_edge("box_x_max", want.x_max, o_m_axis_tdata[63:32]);
                check_edge("box_y_min", want.y_min, o_m_axis_tdata[95:64]);
                check_edge("box_y_max", want.y_max, o_m_axis_tdata[127:96]);
                boxes_checked++;
            end
        end
    end

    // Watchdog: give up once no word has moved on either side for too long
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Wait until every arc is taken and every box has come back
    task automatic drain();
        while (arc_queue.size() != 0 || box_expect.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        // Directed arcs: zero and full radius, equal angles both ways,
        // wrap-around sweeps, endpoints on and beside the axis extremes,
        // and centres at the rails so that edges saturate.
        queue_arc(32'h0, 32'h0, 31'h0, 16'h0000, 16'h0000, 1'b1);
        queue_arc(32'h0, 32'h0, 31'h000A_0000, 16'h0000, 16'h0000, 1'b0);
        queue_arc(32'h0, 32'h0, 31'h0001_0000, 16'h0000, 16'h4000, 1'b1);
        queue_arc(32'h0, 32'h0, 31'h0001_0000, 16'h0000, 16'h4000, 1'b0);
        queue_arc(32'h0, 32'h0, 31'h0010_0000, 16'h4000, 16'h0000, 1'b1);
        queue_arc(32'h0, 32'h0, 31'h0010_0000, 16'h4000, 16'h0000, 1'b0);
        queue_arc(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 16'h0000, 16'h8000, 1'b1);
        queue_arc(32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 16'h8000, 16'h0000, 1'b1);
        queue_arc(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 16'h0000, 16'h0000, 1'b1);
        queue_arc(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 16'd12345, 16'd54321, 1'b0);
        queue_arc(32'h0, 32'h0, 31'h7FFF_FFFF, 16'hFFFF, 16'h0000, 1'b1);
        queue_arc(32'h0, 32'h0, 31'h7FFF_FFFF, 16'h0000, 16'hFFFF, 1'b0);
        queue_arc(32'h0000_0001, 32'hFFFF_FFFF, 31'h1, 16'hC000, 16'hC000, 1'b0);
        queue_arc(32'h1234_5678, 32'hEDCB_A988, 31'h1234_5678, 16'h3FFF, 16'h4001, 1'b1);
        queue_arc(32'h0, 32'h0, 31'h0100_0000, 16'hC000, 16'h3FFF, 1'b0);
        queue_arc(32'h0, 32'h0, 31'h0100_0000, 16'h8000, 16'h8000, 1'b1);
        queue_arc(32'h0, 32'h0, 31'h0100_0000, 16'h3FFF, 16'h3FFF, 1'b0);
        queue_arc(32'hAAAA_AAAA, 32'h5555_5555, 31'h2AAA_AAAA, 16'hAAAA, 16'h5555, 1'b1);
        queue_arc(32'h5555_5555, 32'hAAAA_AAAA, 31'h5555_5555, 16'h5555, 16'hAAAA, 1'b0);
        queue_arc(32'h0, 32'h0, 31'h0040_0000, 16'h0001, 16'hFFFF, 1'b1);
        queue_arc(32'h0, 32'h0, 31'h0040_0000, 16'hFFFF, 16'h0001, 1'b0);
        repeat (RANDOM_PER_MIX) arc_queue = {arc_queue, random_arc()};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sender mostly busy, receiver mostly stalling
        drain();

        // Swap the idling: sparse sender, eager receiver
        tx_idle_pct = 74;
        rx_idle_pct = 30;
        repeat (RANDOM_PER_MIX) arc_queue = {arc_queue, random_arc()};
        drain();

        // Full rate both ways, with one long receiver hold-off so the
        // pipeline fills and the input stalls
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (RANDOM_PER_MIX) arc_queue = {arc_queue, random_arc()};
        hold_requests = hold_requests + 1;
        drain();

        repeat (LATENCY + 10) @(posedge i_clk);
        if (box_expect.size() != 0) begin
            $error("%0d predicted boxes never arrived", box_expect.size());
            fail_count++;
        end

        $display("Covered %0d arcs (%0d clockwise, %0d with equal angles), %0d boxes checked,",
                 arcs_sent, arcs_cw, arcs_equal, boxes_checked);
        $display("%0d with a saturated edge; %0d long receiver hold-off(s) of %0d cycles.",
                 boxes_saturated, hold_served, HOLD_OFF_CYCLES);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
